>>> rtl/core/hlfp_pkg.sv
// Shared types and constants for the header/length frame parser.
// Holds the parse phases, byte roles, register indexes and result beat layout.
// No dependencies.
package hlfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int ROLE_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int USER_W      = ROLE_W + 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] LENGTH_LIMIT_RESET = WORD_W'(1024 * 10);
    localparam logic [WORD_W-1:0] LENGTH_MIN         = WORD_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_WORD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIVER_ENABLE = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT_LO = 3'd0,
        PH_HUNT_HI = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_TYPE0   = 3'd4,
        PH_TYPE1   = 3'd5,
        PH_BODY    = 3'd6
    } phase_t;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_LENGTH  = 3'd1,
        ROLE_TYPE    = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_CHECK   = 3'd4,
        ROLE_ABORT   = 3'd5
    } role_t;

    typedef struct packed {
        logic [WORD_W-1:0] header_word;
        logic [WORD_W-1:0] length_limit;
        logic              deliver_enable;
    } cfg_t;

    typedef struct packed {
        logic              deliver;
        logic              frame_ok;
        role_t             byte_role;
        logic [BYTE_W-1:0] out_byte;
    } result_t;

    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

>>> rtl/core/hlfp_cfg.sv
// Configuration register bank of the frame parser.
// Depends on hlfp_pkg for the register indexes and the cfg_t bundle.
module hlfp_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hlfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hlfp_pkg::WORD_W-1:0]    cfg_data,
    output hlfp_pkg::cfg_t                 cfg
);
    import hlfp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER_WORD:    cfg_next.header_word    = cfg_data;
                REG_LENGTH_LIMIT:   cfg_next.length_limit   = cfg_data;
                REG_DELIVER_ENABLE: cfg_next.deliver_enable = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_word    <= '0;
            cfg_reg.length_limit   <= LENGTH_LIMIT_RESET;
            cfg_reg.deliver_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/hlfp_parser.sv
// Per-byte frame parsing step: phase, length and running XOR state.
// Produces up to two result beats per byte. Depends on hlfp_pkg.
module hlfp_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  logic [hlfp_pkg::BYTE_W-1:0] rx_byte,
    input  hlfp_pkg::cfg_t              cfg,
    output hlfp_pkg::push_t             push
);
    import hlfp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [WORD_W-1:0] remaining_reg, remaining_next;
    logic [BYTE_W-1:0] length_low_reg, length_low_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;

    logic              retry;
    logic              ok;
    logic [WORD_W-1:0] len;
    logic [BYTE_W-1:0] hlo;
    logic [BYTE_W-1:0] hhi;
    result_t           hdr_item;
    result_t           abort_item;

    assign hlo        = cfg.header_word[BYTE_W-1:0];
    assign hhi        = cfg.header_word[WORD_W-1:BYTE_W];
    assign len        = {rx_byte, length_low_reg};
    assign ok         = ((xor_reg ^ rx_byte) == '0);
    assign hdr_item   = '{deliver: 1'b0, frame_ok: 1'b0, byte_role: ROLE_HEADER,
                          out_byte: rx_byte};
    assign abort_item = '{deliver: 1'b0, frame_ok: 1'b0, byte_role: ROLE_ABORT,
                          out_byte: '0};

    always_comb
    begin
        phase_next      = phase_reg;
        remaining_next  = remaining_reg;
        length_low_next = length_low_reg;
        xor_next        = xor_reg;
        retry           = 1'b0;
        push.v0         = 1'b0;
        push.v1         = 1'b0;
        push.r0         = abort_item;
        push.r1         = hdr_item;

        unique case (phase_reg)
            PH_HUNT_LO:
            begin
                if (rx_byte == hlo)
                begin
                    push.v0    = 1'b1;
                    push.r0    = hdr_item;
                    phase_next = PH_HUNT_HI;
                end
            end
            PH_HUNT_HI:
            begin
                push.v0 = 1'b1;
                if (rx_byte == hhi)
                begin
                    push.r0    = hdr_item;
                    phase_next = PH_LEN_LO;
                end
                else
                begin
                    retry = 1'b1;
                end
            end
            PH_LEN_LO:
            begin
                length_low_next = rx_byte;
                push.v0         = 1'b1;
                push.r0         = '{1'b0, 1'b0, ROLE_LENGTH, rx_byte};
                phase_next      = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                push.v0 = 1'b1;
                if ((len > cfg.length_limit) || (len < LENGTH_MIN))
                begin
                    retry = 1'b1;
                end
                else
                begin
                    push.r0        = '{1'b0, 1'b0, ROLE_LENGTH, rx_byte};
                    remaining_next = len - LENGTH_MIN;
                    phase_next     = PH_TYPE0;
                end
            end
            PH_TYPE0:
            begin
                xor_next   = rx_byte;
                push.v0    = 1'b1;
                push.r0    = '{1'b0, 1'b0, ROLE_TYPE, rx_byte};
                phase_next = PH_TYPE1;
            end
            PH_TYPE1:
            begin
                xor_next   = xor_reg ^ rx_byte;
                push.v0    = 1'b1;
                push.r0    = '{1'b0, 1'b0, ROLE_TYPE, rx_byte};
                phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                xor_next = xor_reg ^ rx_byte;
                push.v0  = 1'b1;
                if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - WORD_W'(1);
                    push.r0        = '{1'b0, 1'b0, ROLE_PAYLOAD, rx_byte};
                end
                else
                begin
                    push.r0    = '{ok & cfg.deliver_enable, ok, ROLE_CHECK, rx_byte};
                    phase_next = PH_HUNT_LO;
                end
            end
            default:
            begin
                retry = 1'b1;
            end
        endcase

        // An aborted frame, or a stray phase code, looks at the same byte again
        // as the low header byte.
        if (retry)
        begin
            phase_next = PH_HUNT_LO;
            if (rx_byte == hlo)
            begin
                phase_next = PH_HUNT_HI;
                if (push.v0)
                begin
                    push.v1 = 1'b1;
                    push.r1 = hdr_item;
                end
                else
                begin
                    push.v0 = 1'b1;
                    push.r0 = hdr_item;
                end
            end
        end

        if (!step_en)
        begin
            push.v0 = 1'b0;
            push.v1 = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT_LO;
            remaining_reg  <= '0;
            length_low_reg <= '0;
            xor_reg        <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            remaining_reg  <= remaining_next;
            length_low_reg <= length_low_next;
            xor_reg        <= xor_next;
        end
    end

endmodule

>>> rtl/core/hlfp_out_queue.sv
// Result queue of the frame parser: takes up to two beats a cycle, sends one.
// Depends on hlfp_pkg for result_t, push_t and the queue depth.
module hlfp_out_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hlfp_pkg::push_t             push,
    output logic                        room,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hlfp_pkg::result_t           out_item
);
    import hlfp_pkg::*;

    result_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;
    logic [QCNT_W-1:0] n_push;

    assign pop       = out_valid && out_ready;
    assign n_push    = QCNT_W'(push.v0) + QCNT_W'(push.v1);
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + n_push - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wr_ptr_reg + QPTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/header_length_frame_parser_xor.sv
// Top level of the header/length frame parser with XOR check byte.
// Instantiates hlfp_cfg, hlfp_parser and hlfp_out_queue; depends on hlfp_pkg.
//
// The parser takes one received byte per clock cycle while the queue has room and
// emits each frame byte with its role from a registered four-entry result queue.
// Most bytes give one result beat; a byte that aborts a frame and also matches the
// low header byte gives two, which leave the queue one after the other. The input
// accepts a byte whenever the queue holds at most two beats, so with the output side
// always ready the sustained rate is one byte per cycle. The user must write configuration
// through the plain write port while no frame traffic is in flight; the block does not enforce it.
module header_length_frame_parser_xor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hlfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hlfp_pkg::WORD_W-1:0]    cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [7:0] out_byte
    output logic [hlfp_pkg::USER_W-1:0]    m_axis_tuser   // [2:0] byte_role, [3] frame_ok,
                                                          // [4] deliver
);
    import hlfp_pkg::*;

    cfg_t    cfg;
    push_t   push;
    result_t out_item;
    logic    room;
    logic    step_en;

    assign s_axis_tready = room;
    assign step_en       = s_axis_tvalid && room;

    hlfp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hlfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .rx_byte (s_axis_tdata),
        .cfg     (cfg),
        .push    (push)
    );

    hlfp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = out_item.out_byte;
    assign m_axis_tuser = {out_item.deliver, out_item.frame_ok, out_item.byte_role};

endmodule
